/* rtl/iaf_pkg.sv */
// Shared types and constants for the integer ALU with single-precision result.
package iaf_pkg;

  // Operator codes (ASCII)
  localparam logic [7:0] OP_ADD = 8'd43;
  localparam logic [7:0] OP_SUB = 8'd45;
  localparam logic [7:0] OP_MUL = 8'd42;
  localparam logic [7:0] OP_DIV = 8'd47;
  localparam logic [7:0] OP_REM = 8'd37;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_OP   = 2'd1;
  localparam logic [1:0] ST_REM_ZERO = 2'd2;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  // One divider cell per quotient bit
  localparam int NCELL = 32;

  typedef enum logic [1:0] {
    KIND_INT,
    KIND_DIV,
    KIND_REM,
    KIND_BAD
  } kind_t;

  // Long-division working set handed from cell to cell
  typedef struct packed {
    logic [31:0] r;   // partial remainder
    logic [31:0] d;   // divisor
    logic [31:0] n;   // dividend bits still to shift in
    logic [31:0] q;   // quotient bits so far
  } cell_t;

  // Per-item sideband that rides along the chain
  typedef struct packed {
    kind_t       kind;
    logic [1:0]  status;
    logic        sign;
    logic [7:0]  exp;
    logic        special;
    logic [31:0] spec_bits;
    logic [31:0] ires;
  } side_t;

endpackage

/* rtl/iaf_i2f.sv */
// Two-stage signed 32-bit integer to single-precision converter, round to nearest even.
module iaf_i2f (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] value,
  output logic [31:0] bits
);

  logic        sign_a;
  logic [31:0] mag_a;
  logic [4:0]  lz_a;
  logic [31:0] mag_c;
  logic [4:0]  lz_c;

  logic [31:0] norm;
  logic        rnd;
  logic [24:0] sum;
  logic [7:0]  exp_c;
  logic [22:0] frac_c;

  // Stage A: magnitude and leading-zero count
  always_comb begin
    mag_c = value[31] ? (~value + 32'd1) : value;
    lz_c  = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag_c[i]) lz_c = 5'(31 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sign_a <= value[31];
      mag_a  <= mag_c;
      lz_a   <= lz_c;
    end
  end

  // Stage B: normalize and round
  always_comb begin
    norm   = mag_a << lz_a;
    rnd    = norm[7] & ((|norm[6:0]) | norm[8]);
    sum    = {1'b0, norm[31:8]} + {24'd0, rnd};
    exp_c  = 8'd158 - {3'd0, lz_a} + {7'd0, sum[24]};
    frac_c = sum[24] ? 23'd0 : sum[22:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bits <= (mag_a == 32'd0) ? 32'd0 : {sign_a, exp_c, frac_c};
    end
  end

endmodule

/* rtl/iaf_cell.sv */
// One restoring long-division step, registered.
module iaf_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  iaf_pkg::cell_t  in_data,
  input  iaf_pkg::side_t  in_side,
  output logic            out_valid,
  output iaf_pkg::cell_t  out_data,
  output iaf_pkg::side_t  out_side
);

  logic [32:0] t;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    t    = {in_data.r, in_data.n[31]};
    diff = t - {1'b0, in_data.d};
    ge   = (t >= {1'b0, in_data.d});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.r <= ge ? diff[31:0] : t[31:0];
      out_data.d <= in_data.d;
      out_data.n <= {in_data.n[30:0], 1'b0};
      out_data.q <= {in_data.q[30:0], ge};
      out_side   <= in_side;
    end
  end

endmodule

/* rtl/int_alu_float_result.sv */
// Pipeline from input transfer to result on m_tvalid: input register, 2 convert,
//   32 divider cells, 2 convert, output register.
// Throughput: one item per cycle unless stalled; 32-cell long-division chain, a bit per cell.
// The whole pipeline advances together and holds while a result waits on m_tready.
// Reset: synchronous active-high rst clears every stage valid; no result is pending after it.
module int_alu_float_result (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // func[7:0], operand_a[39:8], operand_b[71:40]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // result_bits[31:0], status[33:32], zero pad[39:34]
);

  // Global advance: every stage moves when the output register can take a new item
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // ---------------- stage 1: input register ----------------
  logic        v1;
  logic [7:0]  func1;
  logic [31:0] a1, b1;
  logic [31:0] ires_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      func1 <= s_tdata[7:0];
      a1    <= s_tdata[39:8];
      b1    <= s_tdata[71:40];
    end
  end

  // wrapping integer result for add, sub and mul
  always_comb begin
    case (func1)
      iaf_pkg::OP_SUB: ires_c = a1 - b1;
      iaf_pkg::OP_MUL: ires_c = a1 * b1;
      default:         ires_c = a1 + b1;
    endcase
  end

  // ---------------- stages 2-3: operand conversion ----------------
  logic [31:0] fa, fb;
  logic        v2, v3;
  logic [7:0]  func2, func3;
  logic [31:0] a2, a3, b2, b3, ires2, ires3;

  iaf_i2f u_cvt_a (.clk(clk), .en(adv), .value(a1), .bits(fa));
  iaf_i2f u_cvt_b (.clk(clk), .en(adv), .value(b1), .bits(fb));

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      func2 <= func1;
      a2    <= a1;
      b2    <= b1;
      ires2 <= ires_c;
      func3 <= func2;
      a3    <= a2;
      b3    <= b2;
      ires3 <= ires2;
    end
  end

  // ---------------- prep: load the divider chain ----------------
  iaf_pkg::cell_t prep_data;
  iaf_pkg::side_t prep_side;
  logic [23:0]    ma, mb;
  logic           za, zb, mge;
  logic [9:0]     dexp;

  always_comb begin
    ma   = {1'b1, fa[22:0]};
    mb   = {1'b1, fb[22:0]};
    za   = (fa[30:0] == 31'd0);
    zb   = (fb[30:0] == 31'd0);
    mge  = (ma >= mb);
    // biased exponent of the quotient before rounding carry
    dexp = {2'd0, fa[30:23]} - {2'd0, fb[30:23]} + {9'd0, mge} + 10'd126;

    prep_side.kind      = iaf_pkg::KIND_BAD;
    prep_side.status    = iaf_pkg::ST_OK;
    prep_side.sign      = 1'b0;
    prep_side.exp       = dexp[7:0];
    prep_side.special   = 1'b0;
    prep_side.spec_bits = 32'd0;
    prep_side.ires      = ires3;
    prep_data.r         = 32'd0;
    prep_data.d         = 32'd1;
    prep_data.n         = 32'd0;
    prep_data.q         = 32'd0;

    unique case (func3) inside
      iaf_pkg::OP_ADD, iaf_pkg::OP_SUB, iaf_pkg::OP_MUL: begin
        prep_side.kind = iaf_pkg::KIND_INT;
      end
      iaf_pkg::OP_DIV: begin
        prep_side.kind = iaf_pkg::KIND_DIV;
        prep_side.sign = fa[31] ^ fb[31];
        // divisor doubled when mantissa A >= B so the quotient lands in [0.5, 1)
        prep_data.r    = {8'd0, ma};
        prep_data.d    = mge ? {7'd0, mb, 1'b0} : {8'd0, mb};
        if (zb) begin
          prep_side.special   = 1'b1;
          prep_side.spec_bits = za ? iaf_pkg::CANON_NAN
                                   : {fa[31] ^ fb[31], 8'hFF, 23'd0};
        end else if (za) begin
          prep_side.special   = 1'b1;
          prep_side.spec_bits = {fa[31] ^ fb[31], 31'd0};
        end
      end
      iaf_pkg::OP_REM: begin
        prep_side.kind = iaf_pkg::KIND_REM;
        prep_side.sign = a3[31];
        prep_data.n    = a3[31] ? (~a3 + 32'd1) : a3;
        prep_data.d    = b3[31] ? (~b3 + 32'd1) : b3;
        if (b3 == 32'd0) prep_side.status = iaf_pkg::ST_REM_ZERO;
      end
      default: begin
        prep_side.status = iaf_pkg::ST_BAD_OP;
      end
    endcase
  end

  // ---------------- divider chain ----------------
  logic           cv   [iaf_pkg::NCELL+1];
  iaf_pkg::cell_t cd   [iaf_pkg::NCELL+1];
  iaf_pkg::side_t cs   [iaf_pkg::NCELL+1];
  logic [iaf_pkg::NCELL-1:0] chain_vld;

  assign cv[0] = v3;
  assign cd[0] = prep_data;
  assign cs[0] = prep_side;

  for (genvar g = 0; g < iaf_pkg::NCELL; g++) begin : g_cell
    iaf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_valid (cv[g]),
      .in_data  (cd[g]),
      .in_side  (cs[g]),
      .out_valid(cv[g+1]),
      .out_data (cd[g+1]),
      .out_side (cs[g+1])
    );
    assign chain_vld[g] = cv[g+1];
  end

  // ---------------- post: round quotient, convert integer result ----------------
  iaf_pkg::cell_t last_d;
  iaf_pkg::side_t last_s;
  logic [31:0]    remv, int_val, divbits_c, ibits;
  logic           sticky, qrnd;
  logic [24:0]    qsum;
  logic [7:0]     qexp;
  logic [22:0]    qfrac;

  assign last_d = cd[iaf_pkg::NCELL];
  assign last_s = cs[iaf_pkg::NCELL];

  always_comb begin
    remv    = last_s.sign ? (~last_d.r + 32'd1) : last_d.r;
    int_val = (last_s.kind == iaf_pkg::KIND_REM) ? remv : last_s.ires;

    sticky  = (|last_d.q[6:0]) | (|last_d.r);
    qrnd    = last_d.q[7] & (sticky | last_d.q[8]);
    qsum    = {1'b0, last_d.q[31:8]} + {24'd0, qrnd};
    qexp    = last_s.exp + {7'd0, qsum[24]};
    qfrac   = qsum[24] ? 23'd0 : qsum[22:0];
    divbits_c = last_s.special ? last_s.spec_bits : {last_s.sign, qexp, qfrac};
  end

  iaf_i2f u_cvt_r (.clk(clk), .en(adv), .value(int_val), .bits(ibits));

  logic           pv1, pv2;
  iaf_pkg::side_t ps1, ps2;
  logic [31:0]    db1, db2;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv1 <= 1'b0;
      pv2 <= 1'b0;
    end else if (adv) begin
      pv1 <= cv[iaf_pkg::NCELL];
      pv2 <= pv1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ps1 <= last_s;
      ps2 <= ps1;
      db1 <= divbits_c;
      db2 <= db1;
    end
  end

  // ---------------- output register ----------------
  logic [31:0] res_c;

  always_comb begin
    if (ps2.status != iaf_pkg::ST_OK) begin
      res_c = 32'd0;
    end else if (ps2.kind == iaf_pkg::KIND_DIV) begin
      res_c = db2;
    end else begin
      res_c = ibits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= pv2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {6'd0, ps2.status, res_c};
    end
  end

`ifndef NO_ASSERTIONS
  // any nonzero status must come with a +0.0 result
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[33:32] != iaf_pkg::ST_OK) |-> (m_tdata[31:0] == 32'd0))
    else $error("nonzero status with nonzero result");

  // a stalled pipeline keeps every cell's occupancy
  a_chain_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(chain_vld))
    else $error("divider chain moved during stall");

  // a new result appears only from the last post stage
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(pv2))
    else $error("result without an item behind it");
`endif

endmodule
